>>> rtl/core/lbp7_pkg.sv
// Shared constants and types for the radius-seven LBP pixel coder.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package lbp7_pkg;

   localparam int PIX_W          = 8;
   localparam int RADIUS         = 7;
   localparam int NUM_SAMPLES    = 8;
   localparam int NUM_POINTS     = NUM_SAMPLES + 1;   // samples plus centre
   localparam int CENTRE         = NUM_SAMPLES;
   localparam int LINES          = 2 * RADIUS;        // stored rows behind the newest
   localparam int TAP_W          = LINES * PIX_W;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int CFG_WIDTH_W    = 9;
   localparam int CFG_HEIGHT_W   = 10;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 10;
   localparam int FRAME_WIDTH_RESET  = 256;
   localparam int FRAME_HEIGHT_RESET = 512;
   localparam int MIN_FRAME_WIDTH    = 8;

   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // (row, column) offsets of the sample points; last entry is the centre
   localparam int ROW_OFF [NUM_POINTS] = '{7, 5, 1, -5, -7, -6, -1, 4, 0};
   localparam int COL_OFF [NUM_POINTS] = '{1, -5, -7, -6, -1, 4, 7, 5, 0};

   typedef struct packed {
      logic accept;   // transaction taken into stage 1
      logic shift;    // stage 1 item moves on: line store write, history shift
      logic load2;    // stage 2 registers load
      logic load3;    // stage 3 (output) registers load
   } pipe_ctrl_type;

endpackage

>>> rtl/core/radius_seven_lbp_pixel_coder_unit.sv
// Top level of the radius-seven LBP pixel coder: raster counters, CSRs, pipeline control.
// Depends on lbp7_pkg, lbp7_window and lbp7_code.
//
//   port group | direction | flow control  | carries
//   req_*      | in        | valid / stall | operation, pixel
//   rsp_*      | out       | valid / stall | lbp_code, last
//   csr_*      | in        | valid / ready | index, wdata (frame_width, frame_height)
//
// One transaction per clock while rsp_stall is low; the transaction that completes a
// window (pixel k + 7*width + 7) passes stages 1, 2 and 3, and its code leaves stage 3.
// Window rows come from one line memory read per transaction at its column.
// Reset clears counters and valid bits and loads the CSRs with their reset values; the
// line memory is never cleared, out-of-frame points are masked to zero instead.
// Empty stages are filled while the output is stalled; nothing is dropped or repeated.
`timescale 1ns / 1ps

module radius_seven_lbp_pixel_coder_unit import lbp7_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [PIX_W-1:0]       req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_SAMPLES-1:0] rsp_lbp_code,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int KR_W   = $clog2(MAX_HEIGHT);
   localparam int ROWP_W = $clog2(MAX_HEIGHT + RADIUS + 2);
   localparam int WSAT_W = (WID_W > CFG_WIDTH_W) ? WID_W : CFG_WIDTH_W;
   localparam int HSAT_W = (HGT_W > CFG_HEIGHT_W) ? HGT_W : CFG_HEIGHT_W;
   localparam int RST_WIDTH  = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : FRAME_WIDTH_RESET;
   localparam int RST_HEIGHT = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : FRAME_HEIGHT_RESET;

   // ---------------- CSRs (stored already clamped) ----------------
   logic [WID_W-1:0]        width_ff, width_in;
   logic [HGT_W-1:0]        height_ff, height_in;
   logic [CFG_WIDTH_W-1:0]  raw_w;
   logic [CFG_HEIGHT_W-1:0] raw_h;
   logic [WID_W-1:0]        sat_w;
   logic [HGT_W-1:0]        sat_h;

   assign csr_ready = 1'b1;
   assign raw_w = csr_wdata[CFG_WIDTH_W-1:0];
   assign raw_h = csr_wdata[CFG_HEIGHT_W-1:0];

   always_comb begin
      priority if (WSAT_W'(raw_w) < WSAT_W'(MIN_FRAME_WIDTH)) begin
         sat_w = WID_W'(MIN_FRAME_WIDTH);
      end else if (WSAT_W'(raw_w) > WSAT_W'(MAX_WIDTH)) begin
         sat_w = WID_W'(MAX_WIDTH);
      end else begin
         sat_w = WID_W'(raw_w);
      end
      priority if (raw_h == '0) begin
         sat_h = HGT_W'(1);
      end else if (HSAT_W'(raw_h) > HSAT_W'(MAX_HEIGHT)) begin
         sat_h = HGT_W'(MAX_HEIGHT);
      end else begin
         sat_h = HGT_W'(raw_h);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = sat_w;
            CSR_FRAME_HEIGHT: height_in = sat_h;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(RST_WIDTH);
         height_ff <= HGT_W'(RST_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------- pipeline handshake ----------------
   logic          v1_ff, v2_ff, v3_ff;
   logic          rdy1, rdy2, rdy3;
   logic          out1_ff, out2_ff;
   pipe_ctrl_type ctrl;

   assign rdy3 = !v3_ff || !rsp_stall;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall    = !rdy1;
   assign ctrl.accept  = req_valid && rdy1;
   assign ctrl.shift   = v1_ff && rdy2;
   assign ctrl.load2   = rdy2;
   assign ctrl.load3   = rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff && out2_ff;   // items without a code stop here
      end
   end

   // ---------------- raster position of the incoming transaction ----------------
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROWP_W-1:0]   row_ff, row_in;
   logic                col_past_r;
   logic [WID_W-1:0]    kc_wide;
   logic signed [ROWP_W:0] kr;
   logic [ROWP_W-1:0]   kr_mag;
   logic [ROWP_W-1:0]   h_ext;
   logic                k_in, k_past, k_last, end_row;

   assign col_past_r = (col_ff >= COL_W'(RADIUS));
   assign kc_wide = col_past_r ? (WID_W'(col_ff) - WID_W'(RADIUS))
                               : (WID_W'(col_ff) + width_ff - WID_W'(RADIUS));
   assign kr      = (ROWP_W+1)'(row_ff)
                    - (col_past_r ? (ROWP_W+1)'(RADIUS) : (ROWP_W+1)'(RADIUS + 1));
   assign kr_mag  = kr[ROWP_W-1:0];
   assign h_ext   = ROWP_W'(height_ff);
   assign k_in    = !kr[ROWP_W] && (kr_mag < h_ext);
   assign k_past  = !kr[ROWP_W] && (kr_mag >= h_ext);
   assign k_last  = k_in && (kr_mag == h_ext - ROWP_W'(1))
                         && (kc_wide == width_ff - WID_W'(1));
   assign end_row = (WID_W'(col_ff) + WID_W'(1) == width_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.accept) begin
         priority if (k_last || k_past) begin
            col_in = '0;
            row_in = '0;
         end else if (end_row) begin
            col_in = '0;
            row_in = row_ff + ROWP_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- stage 1 registers ----------------
   logic [PIX_W-1:0] pix1_ff;
   logic [COL_W-1:0] col1_ff;
   logic [KR_W-1:0]  kr1_ff;
   logic [COL_W-1:0] kc1_ff;
   logic             last1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         pix1_ff  <= (req_operation == OP_DRAIN) ? '0 : req_pixel;
         col1_ff  <= col_ff;
         kr1_ff   <= kr_mag[KR_W-1:0];
         kc1_ff   <= kc_wide[COL_W-1:0];
         last1_ff <= k_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out1_ff <= 1'b0;
         out2_ff <= 1'b0;
      end else begin
         if (ctrl.accept) out1_ff <= k_in;
         if (ctrl.load2)  out2_ff <= out1_ff;
      end
   end

   // ---------------- datapath ----------------
   logic [PIX_W-1:0] sample [NUM_POINTS];

   lbp7_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_addr (col_ff),
      .wr_addr (col1_ff),
      .pix     (pix1_ff),
      .sample  (sample)
   );

   lbp7_code #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_code (
      .clock      (clock),
      .ctrl       (ctrl),
      .width      (width_ff),
      .height     (height_ff),
      .centre_row (kr1_ff),
      .centre_col (kc1_ff),
      .last       (last1_ff),
      .sample     (sample),
      .lbp_code   (rsp_lbp_code),
      .lbp_last   (rsp_last)
   );

   assign rsp_valid = v3_ff;

endmodule

>>> rtl/core/lbp7_window.sv
// Line store and column history: delivers the nine window points of stage 1.
// Depends on lbp7_pkg.
`timescale 1ns / 1ps

module lbp7_window import lbp7_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  pipe_ctrl_type                ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [PIX_W-1:0]             pix,
   output logic [PIX_W-1:0]             sample [NUM_POINTS]
);

   // one word per column holds that column's last LINES rows, newest lowest
   logic [TAP_W-1:0] mem [MAX_WIDTH];
   logic [TAP_W-1:0] rd_ff;
   logic [PIX_W-1:0] tap [LINES+1];

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         mem[wr_addr] <= {rd_ff[TAP_W-PIX_W-1:0], pix};
      end
   end

   assign tap[0] = pix;

   for (genvar t = 1; t <= LINES; t++) begin : g_tap
      assign tap[t] = rd_ff[(t-1)*PIX_W +: PIX_W];
   end

   for (genvar n = 0; n < NUM_POINTS; n++) begin : g_point
      localparam int RD = RADIUS - ROW_OFF[n];
      localparam int CD = RADIUS - COL_OFF[n];
      if (CD == 0) begin : g_now
         assign sample[n] = tap[RD];
      end else begin : g_dly
         logic [PIX_W-1:0] dly_ff [CD];
         always_ff @(posedge clock) begin
            if (ctrl.shift) begin
               dly_ff[0] <= tap[RD];
               for (int j = 1; j < CD; j++) begin
                  dly_ff[j] <= dly_ff[j-1];
               end
            end
         end
         assign sample[n] = dly_ff[CD-1];
      end
   end

endmodule

>>> rtl/core/lbp7_code.sv
// Edge masking (stage 1 to 2) and threshold compare (stage 2 to 3) of the coder.
// Depends on lbp7_pkg.
`timescale 1ns / 1ps

module lbp7_code import lbp7_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  pipe_ctrl_type                      ctrl,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height,
   input  logic [$clog2(MAX_HEIGHT)-1:0]      centre_row,
   input  logic [$clog2(MAX_WIDTH)-1:0]       centre_col,
   input  logic                               last,
   input  logic [PIX_W-1:0]                   sample [NUM_POINTS],
   output logic [NUM_SAMPLES-1:0]             lbp_code,
   output logic                               lbp_last
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int RCW   = HGT_W + 2;
   localparam int CCW   = WID_W + 2;

   logic signed [RCW-1:0] h_ext;
   logic signed [CCW-1:0] w_ext;
   logic [PIX_W-1:0]      masked    [NUM_POINTS];
   logic [PIX_W-1:0]      pt2_ff    [NUM_POINTS];
   logic                  last2_ff;
   logic [NUM_SAMPLES-1:0] code_in;
   logic [NUM_SAMPLES-1:0] code3_ff;
   logic                  last3_ff;

   assign h_ext = RCW'(height);
   assign w_ext = CCW'(width);

   // points beyond the frame edge read as zero
   for (genvar n = 0; n < NUM_SAMPLES; n++) begin : g_mask
      logic signed [RCW-1:0] roff;
      logic signed [CCW-1:0] coff;
      logic signed [RCW-1:0] rr;
      logic signed [CCW-1:0] cc;
      logic                  inside_frame;
      assign roff = RCW'(ROW_OFF[n]);
      assign coff = CCW'(COL_OFF[n]);
      assign rr   = RCW'(centre_row) + roff;
      assign cc   = CCW'(centre_col) + coff;
      assign inside_frame = !rr[RCW-1] && (rr < h_ext) && !cc[CCW-1] && (cc < w_ext);
      assign masked[n] = inside_frame ? sample[n] : '0;
   end
   assign masked[CENTRE] = sample[CENTRE];

   always_ff @(posedge clock) begin
      if (ctrl.load2) begin
         pt2_ff   <= masked;
         last2_ff <= last;
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SAMPLES; s++) begin
         code_in[s] = (pt2_ff[s] >= pt2_ff[CENTRE]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load3) begin
         code3_ff <= code_in;
         last3_ff <= last2_ff;
      end
   end

   assign lbp_code = code3_ff;
   assign lbp_last = last3_ff;

endmodule
